@@ hw/rtl/esn_pkg.sv @@
// Shared types and constants for the eventual safe nodes block.
// Holds the fixed field widths, the vertex count reset value and the edge entry type.
// No dependencies.
package esn_pkg;

  localparam int NODE_W = 6;
  localparam int CFG_W  = 7;

  localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd64;

  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
  } edge_t;

endpackage

@@ hw/rtl/eventual_safe_nodes_top.sv @@
// Eventual safe nodes: edge loader, reverse topological peel and ascending result scan.
// Depends on esn_pkg for field widths, the vertex count reset value and the edge entry type.
// Loading takes one transaction per cycle with busy low; the item marked last raises busy.
// After it the block clears the degree memory, counts degrees over the stored edges, seeds
// the queue with every vertex of degree zero, walks the stored edges once per dequeued vertex,
// and scans the vertices for results in ascending order; the edge loop runs through the
// single-port edge and degree memories. Results cannot be stalled.
// Synchronous active-low reset clears the graph, the queue and the flag; vertex_count resets to 64.
module eventual_safe_nodes_top #(
  parameter int MAX_V = 64,
  parameter int MAX_E = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [esn_pkg::NODE_W-1:0]  in_src_node,
  input  logic [esn_pkg::NODE_W-1:0]  in_dst_node,
  input  logic                        in_edge_valid,
  input  logic                        in_last_edge,
  output logic                        out_valid,
  output logic [esn_pkg::NODE_W-1:0]  out_safe_node,
  output logic                        out_found,
  output logic                        out_bad_input,
  output logic                        out_last_result,
  input  logic                        cfg_we,
  input  logic [esn_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int NW = esn_pkg::NODE_W;
  localparam int KW = esn_pkg::CFG_W;
  localparam int VW = $clog2(MAX_V);
  localparam int CW = $clog2(MAX_V + 1);
  localparam int EW = (MAX_E > 1) ? $clog2(MAX_E) : 1;
  localparam int TW = $clog2(MAX_E + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_CNT_RD,
    ST_CNT_CHK,
    ST_CNT_UPD,
    ST_SEED_RD,
    ST_SEED_CHK,
    ST_POP,
    ST_DEC_RD,
    ST_DEC_CHK,
    ST_DEC_UPD,
    ST_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [KW-1:0]        vcount_r;
  logic [TW-1:0]        total_r, total_nxt;
  logic                 drop_r, drop_nxt;
  logic [EW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        vidx_r, vidx_nxt;
  logic [CW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        tail_r, tail_nxt;
  logic [CW-1:0]        emitted_r, emitted_nxt;
  logic [MAX_V-1:0]     safe_r, safe_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [NW-1:0]        out_node_r, out_node_nxt;
  logic                 out_found_r, out_found_nxt;
  logic                 out_bad_r, out_bad_nxt;
  logic                 out_last_r, out_last_nxt;

  // Memories and their registered read data.
  esn_pkg::edge_t       edge_mem [MAX_E];
  logic [TW-1:0]        deg_mem  [MAX_V];
  logic [VW-1:0]        queue_mem [MAX_V];
  esn_pkg::edge_t       edge_rd_r;
  logic [TW-1:0]        deg_rd_r;
  logic [VW-1:0]        q_rd_r;

  logic                 accept;
  logic [CW-1:0]        n_w;
  logic                 in_ok;
  logic                 edge_we, edge_re;
  logic                 deg_we, deg_re;
  logic [VW-1:0]        deg_waddr, deg_raddr;
  logic [TW-1:0]        deg_wdata;
  logic                 q_re, q_we;
  logic                 enq_req;
  logic [VW-1:0]        enq_node;
  logic                 edge_last;
  logic                 s_ok, d_ok;
  logic [VW-1:0]        s_idx;
  logic [CW-1:0]        vidx_inc;
  logic                 emit_last;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // A vertex count of zero acts as one and anything above MAX_V acts as MAX_V.
  always_comb begin
    if (vcount_r == '0) begin
      n_w = CW'(1);
    end else if (vcount_r > KW'(MAX_V)) begin
      n_w = CW'(MAX_V);
    end else begin
      n_w = vcount_r[CW-1:0];
    end
  end

  assign in_ok = (total_r < TW'(MAX_E)) &&
                 ({1'b0, in_src_node} < KW'(n_w)) &&
                 ({1'b0, in_dst_node} < KW'(n_w));

  assign edge_last = ((TW'(idx_r) + TW'(1)) >= total_r);
  assign s_ok      = ({1'b0, edge_rd_r.src} < KW'(n_w));
  assign d_ok      = ({1'b0, edge_rd_r.dst} < KW'(n_w));
  assign s_idx     = edge_rd_r.src[VW-1:0];
  assign vidx_inc  = vidx_r + CW'(1);
  assign emit_last = ((emitted_r + CW'(1)) == tail_r);
  assign q_we      = enq_req && (tail_r < CW'(MAX_V));

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    drop_nxt      = drop_r;
    idx_nxt       = idx_r;
    vidx_nxt      = vidx_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    emitted_nxt   = emitted_r;
    safe_nxt      = safe_r;
    out_valid_nxt = 1'b0;
    out_node_nxt  = out_node_r;
    out_found_nxt = out_found_r;
    out_bad_nxt   = out_bad_r;
    out_last_nxt  = out_last_r;
    edge_we       = 1'b0;
    edge_re       = 1'b0;
    deg_we        = 1'b0;
    deg_re        = 1'b0;
    deg_waddr     = vidx_r[VW-1:0];
    deg_raddr     = vidx_r[VW-1:0];
    deg_wdata     = '0;
    q_re          = 1'b0;
    enq_req       = 1'b0;
    enq_node      = vidx_r[VW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_edge_valid) begin
            if (in_ok) begin
              edge_we   = 1'b1;
              total_nxt = total_r + TW'(1);
            end else begin
              drop_nxt = 1'b1;
            end
          end
          if (in_last_edge) begin
            state_nxt = ST_CLR;
            vidx_nxt  = '0;
            head_nxt  = '0;
            tail_nxt  = '0;
            safe_nxt  = '0;
          end
        end
      end

      ST_CLR: begin
        deg_we = 1'b1;
        if (vidx_inc < n_w) begin
          vidx_nxt = vidx_inc;
        end else begin
          vidx_nxt  = '0;
          idx_nxt   = '0;
          state_nxt = (total_r == '0) ? ST_SEED_RD : ST_CNT_RD;
        end
      end

      ST_CNT_RD: begin
        edge_re   = 1'b1;
        state_nxt = ST_CNT_CHK;
      end

      ST_CNT_CHK: begin
        if (s_ok && d_ok) begin
          deg_re    = 1'b1;
          deg_raddr = s_idx;
          state_nxt = ST_CNT_UPD;
        end else if (edge_last) begin
          state_nxt = ST_SEED_RD;
        end else begin
          idx_nxt   = idx_r + EW'(1);
          state_nxt = ST_CNT_RD;
        end
      end

      ST_CNT_UPD: begin
        deg_we    = 1'b1;
        deg_waddr = s_idx;
        deg_wdata = deg_rd_r + TW'(1);
        if (edge_last) begin
          state_nxt = ST_SEED_RD;
        end else begin
          idx_nxt   = idx_r + EW'(1);
          state_nxt = ST_CNT_RD;
        end
      end

      ST_SEED_RD: begin
        deg_re    = 1'b1;
        state_nxt = ST_SEED_CHK;
      end

      ST_SEED_CHK: begin
        if (deg_rd_r == '0) begin
          enq_req = 1'b1;
        end
        if (vidx_inc < n_w) begin
          vidx_nxt  = vidx_inc;
          state_nxt = ST_SEED_RD;
        end else begin
          state_nxt = ST_POP;
        end
      end

      ST_POP: begin
        if (head_r < tail_r) begin
          q_re      = 1'b1;
          head_nxt  = head_r + CW'(1);
          idx_nxt   = '0;
          state_nxt = (total_r == '0) ? ST_POP : ST_DEC_RD;
        end else begin
          vidx_nxt    = '0;
          emitted_nxt = '0;
          state_nxt   = ST_EMIT;
        end
      end

      ST_DEC_RD: begin
        edge_re   = 1'b1;
        state_nxt = ST_DEC_CHK;
      end

      // Only edges that point at the dequeued vertex touch a predecessor's count.
      ST_DEC_CHK: begin
        if ((edge_rd_r.dst == NW'(q_rd_r)) && s_ok) begin
          deg_re    = 1'b1;
          deg_raddr = s_idx;
          state_nxt = ST_DEC_UPD;
        end else if (edge_last) begin
          state_nxt = ST_POP;
        end else begin
          idx_nxt   = idx_r + EW'(1);
          state_nxt = ST_DEC_RD;
        end
      end

      ST_DEC_UPD: begin
        if (deg_rd_r != '0) begin
          deg_we    = 1'b1;
          deg_waddr = s_idx;
          deg_wdata = deg_rd_r - TW'(1);
          if (deg_rd_r == TW'(1)) begin
            enq_req  = 1'b1;
            enq_node = s_idx;
          end
        end
        if (edge_last) begin
          state_nxt = ST_POP;
        end else begin
          idx_nxt   = idx_r + EW'(1);
          state_nxt = ST_DEC_RD;
        end
      end

      // Every queued vertex is safe exactly once, so the tail counts the results.
      ST_EMIT: begin
        if (tail_r == '0) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = '0;
          out_found_nxt = 1'b0;
          out_bad_nxt   = drop_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
          total_nxt     = '0;
          drop_nxt      = 1'b0;
          head_nxt      = '0;
          tail_nxt      = '0;
          safe_nxt      = '0;
        end else begin
          if (safe_r[vidx_r[VW-1:0]]) begin
            out_valid_nxt = 1'b1;
            out_node_nxt  = NW'(vidx_r);
            out_found_nxt = 1'b1;
            out_bad_nxt   = drop_r;
            out_last_nxt  = emit_last;
            emitted_nxt   = emitted_r + CW'(1);
            if (emit_last) begin
              state_nxt = ST_IDLE;
              total_nxt = '0;
              drop_nxt  = 1'b0;
              head_nxt  = '0;
              tail_nxt  = '0;
              safe_nxt  = '0;
            end
          end
          vidx_nxt = vidx_inc;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (enq_req && (tail_r < CW'(MAX_V))) begin
      tail_nxt           = tail_r + CW'(1);
      safe_nxt[enq_node] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcount_r    <= esn_pkg::VCOUNT_RESET;
      total_r     <= '0;
      drop_r      <= 1'b0;
      idx_r       <= '0;
      vidx_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      emitted_r   <= '0;
      safe_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        vcount_r <= cfg_wdata;
      end
      total_r     <= total_nxt;
      drop_r      <= drop_nxt;
      idx_r       <= idx_nxt;
      vidx_r      <= vidx_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      emitted_r   <= emitted_nxt;
      safe_r      <= safe_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_node_r  <= out_node_nxt;
    out_found_r <= out_found_nxt;
    out_bad_r   <= out_bad_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[total_r[EW-1:0]] <= '{src: in_src_node, dst: in_dst_node};
    end
    if (edge_re) begin
      edge_rd_r <= edge_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    if (deg_re) begin
      deg_rd_r <= deg_mem[deg_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[tail_r[VW-1:0]] <= enq_node;
    end
    if (q_re) begin
      q_rd_r <= queue_mem[head_r[VW-1:0]];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_safe_node   = out_node_r;
  assign out_found       = out_found_r;
  assign out_bad_input   = out_bad_r;
  assign out_last_result = out_last_r;

endmodule

@@ verif/safe_nodes_checker.sv @@
// Checker for the eventual safe nodes block: watches the edge, result and vertex count ports.
// It predicts the safe vertices of each graph and compares every result in arrival order.
// Depends on esn_pkg for the field widths, the vertex count reset value and the edge entry type.
module safe_nodes_checker #(
  parameter int MAX_V = 64,
  parameter int MAX_E = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [esn_pkg::NODE_W-1:0]  in_src_node,
  input  logic [esn_pkg::NODE_W-1:0]  in_dst_node,
  input  logic                        in_edge_valid,
  input  logic                        in_last_edge,
  input  logic                        out_valid,
  input  logic [esn_pkg::NODE_W-1:0]  out_safe_node,
  input  logic                        out_found,
  input  logic                        out_bad_input,
  input  logic                        out_last_result,
  input  logic                        cfg_we,
  input  logic [esn_pkg::CFG_W-1:0]   cfg_wdata,
  output int                          fail_count,
  output int                          pending_count
);

  localparam int NW = esn_pkg::NODE_W;
  localparam int KW = esn_pkg::CFG_W;

  typedef struct packed {
    logic [NW-1:0] node;
    logic          found;
    logic          bad;
    logic          last;
  } safe_result_t;

  esn_pkg::edge_t edge_mem [MAX_E];
  int             edge_cnt = 0;
  logic [KW-1:0]  vcount = esn_pkg::VCOUNT_RESET;
  logic           dropped = 1'b0;
  safe_result_t   safe_q [$];
  int             errors = 0;

  function automatic int live_vertices();
    if (vcount == '0) return 1;
    if (int'(vcount) > MAX_V) return MAX_V;
    return int'(vcount);
  endfunction

  function automatic void check_field(string name, logic [NW-1:0] want,
                                      logic [NW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Peel the reversed graph from its sinks and queue one result per reached vertex, or one not-found result if none.
  task automatic predict_safe_nodes();
    int           n;
    int           deg [MAX_V];
    int           fifo [MAX_V];
    bit           reached [MAX_V];
    int           head;
    int           tail;
    int           x;
    int           total;
    int           k;
    safe_result_t r;
    n = live_vertices();
    head = 0;
    tail = 0;
    for (int v = 0; v < MAX_V; v++) begin
      deg[v] = 0;
      reached[v] = 1'b0;
    end
    // Degrees are recounted here, so edges beyond a reduced vertex count drop out.
    for (int i = 0; i < edge_cnt; i++)
      if (edge_mem[i].src < n && edge_mem[i].dst < n) deg[edge_mem[i].src]++;
    for (int v = 0; v < n; v++)
      if (deg[v] == 0) begin
        fifo[tail] = v;
        tail++;
        reached[v] = 1'b1;
      end
    while (head < tail) begin
      x = fifo[head];
      head++;
      for (int i = 0; i < edge_cnt; i++)
        if (edge_mem[i].dst == x && edge_mem[i].src < n && deg[edge_mem[i].src] > 0) begin
          deg[edge_mem[i].src]--;
          if (deg[edge_mem[i].src] == 0) begin
            fifo[tail] = int'(edge_mem[i].src);
            tail++;
            reached[edge_mem[i].src] = 1'b1;
          end
        end
    end
    total = 0;
    for (int v = 0; v < n; v++)
      if (reached[v]) total++;
    if (total == 0) begin
      r = '{node: '0, found: 1'b0, bad: dropped, last: 1'b1};
      safe_q = {safe_q, r};
    end else begin
      k = 0;
      for (int v = 0; v < n; v++)
        if (reached[v]) begin
          k++;
          r = '{node: NW'(v), found: 1'b1, bad: dropped, last: (k == total)};
          safe_q = {safe_q, r};
        end
    end
  endtask

  always @(posedge clk) begin
    safe_result_t want;
    if (!rst_n) begin
      vcount = esn_pkg::VCOUNT_RESET;
      edge_cnt = 0;
      dropped = 1'b0;
      safe_q.delete();
    end else begin
      if (start && !busy) begin
        if (in_edge_valid) begin
          if (edge_cnt < MAX_E && in_src_node < live_vertices() &&
              in_dst_node < live_vertices()) begin
            edge_mem[edge_cnt] = '{src: in_src_node, dst: in_dst_node};
            edge_cnt++;
          end else begin
            dropped = 1'b1;
          end
        end
        if (in_last_edge) begin
          predict_safe_nodes();
          edge_cnt = 0;
          dropped = 1'b0;
        end
      end
      // A register write lands at this edge, after the transaction above has used the old count.
      if (cfg_we) vcount = cfg_wdata;
      if (out_valid) begin
        if (safe_q.size() == 0) begin
          $error("result for vertex %0d arrived with nothing pending", out_safe_node);
          errors++;
        end else begin
          want = safe_q.pop_front();
          check_field("safe_node", want.node, out_safe_node);
          check_field("found", NW'(want.found), NW'(out_found));
          check_field("bad_input", NW'(want.bad), NW'(out_bad_input));
          check_field("last_result", NW'(want.last), NW'(out_last_result));
        end
      end
    end
    fail_count <= errors;
    pending_count <= safe_q.size();
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for eventual_safe_nodes_top: clock, reset, edge stimulus and the verdict.
// Sends directed graphs, then random graphs in bursts, and changes the vertex count while idle.
// Depends on esn_pkg, eventual_safe_nodes_top and safe_nodes_checker.
module tb_top;

  localparam int NW            = esn_pkg::NODE_W;
  localparam int KW            = esn_pkg::CFG_W;
  localparam int MAX_V         = 64;
  localparam int MAX_E         = 256;
  localparam int TOTAL_ITEMS   = 330;
  localparam int IDLE_LIMIT    = 200000;
  localparam int SETTLE_CYCLES = 2 * MAX_V + 16;
  localparam int DRAIN_CYCLES  = 300;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [NW-1:0]     in_src_node = '0;
  logic [NW-1:0]     in_dst_node = '0;
  logic              in_edge_valid = 1'b0;
  logic              in_last_edge = 1'b0;
  logic              out_valid;
  logic [NW-1:0]     out_safe_node;
  logic              out_found;
  logic              out_bad_input;
  logic              out_last_result;
  logic              cfg_we = 1'b0;
  logic [KW-1:0]     cfg_wdata = '0;
  int                fail_count;
  int                pending_count;

  int                burst_left = 0;
  int                sent_items = 0;
  int                idle_cycles = 0;
  logic [KW-1:0]     vcount_now = esn_pkg::VCOUNT_RESET;

  always #5 clk = ~clk;

  eventual_safe_nodes_top #(.MAX_V(MAX_V), .MAX_E(MAX_E)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_src_node(in_src_node), .in_dst_node(in_dst_node),
    .in_edge_valid(in_edge_valid), .in_last_edge(in_last_edge),
    .out_valid(out_valid), .out_safe_node(out_safe_node), .out_found(out_found),
    .out_bad_input(out_bad_input), .out_last_result(out_last_result),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  safe_nodes_checker #(.MAX_V(MAX_V), .MAX_E(MAX_E)) safe_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_src_node(in_src_node), .in_dst_node(in_dst_node),
    .in_edge_valid(in_edge_valid), .in_last_edge(in_last_edge),
    .out_valid(out_valid), .out_safe_node(out_safe_node), .out_found(out_found),
    .out_bad_input(out_bad_input), .out_last_result(out_last_result),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // The run ends if neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("eventual_safe_nodes_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int live_n();
    if (vcount_now == '0) return 1;
    if (int'(vcount_now) > MAX_V) return MAX_V;
    return int'(vcount_now);
  endfunction

  function automatic logic [KW-1:0] pick_vcount();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return KW'(1);
      2: return KW'(MAX_V);
      3: return KW'($urandom_range(MAX_V + 1, 127));
      default: return KW'($urandom_range(2, 24));
    endcase
  endfunction

  task automatic send_item(input logic [NW-1:0] src, input logic [NW-1:0] dst,
                           input logic valid, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    start <= 1'b1;
    in_src_node <= src;
    in_dst_node <= dst;
    in_edge_valid <= valid;
    in_last_edge <= last;
    do @(posedge clk); while (busy);
    sent_items++;
  endtask

  // The block must be idle: every result in, and time for it to clear its tables.
  task automatic write_vcount(input logic [KW-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    vcount_now = value;
  endtask

  task automatic random_graph(input bit big);
    int            n;
    int            edges;
    int            style;
    logic [NW-1:0] s;
    logic [NW-1:0] d;
    if (big) begin
      write_vcount(KW'($urandom_range(2, 6)));
      edges = $urandom_range(MAX_E + 1, MAX_E + 8);
      style = 0;
    end else begin
      if ($urandom_range(0, 2) == 0) write_vcount(pick_vcount());
      edges = $urandom_range(0, 2 * live_n() + 2);
      if (edges > 48) edges = 48;
      style = $urandom_range(0, 2);
    end
    n = live_n();
    for (int e = 0; e < edges; e++) begin
      if (!big && $urandom_range(0, 11) == 0) begin
        send_item(NW'($urandom), NW'($urandom), 1'b0, 1'b0);
      end
      if (!big && $urandom_range(0, 29) == 0) begin
        write_vcount(pick_vcount());
        n = live_n();
      end
      // Style zero builds edges from lower to higher vertices when n is above one, so these edges form no cycle.
      if (style == 0 && n > 1) begin
        s = NW'($urandom_range(0, n - 2));
        d = NW'($urandom_range(int'(s) + 1, n - 1));
      end else begin
        s = NW'($urandom_range(0, n - 1));
        d = NW'($urandom_range(0, n - 1));
      end
      if (!big && $urandom_range(0, 9) == 0) begin
        if (n == MAX_V) s = NW'($urandom);
        else if ($urandom_range(0, 1) == 0) s = NW'($urandom_range(n, 63));
        else d = NW'($urandom_range(n, 63));
      end
      send_item(s, d, 1'b1, 1'b0);
    end
    s = NW'($urandom_range(0, n - 1));
    d = NW'($urandom_range(0, n - 1));
    send_item(s, d, 1'($urandom_range(0, 1)), 1'b1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Duplicate edge, self-loop, ignored item, dropped edge, and an edge on the last item.
    write_vcount(7'd4);
    send_item(6'd0, 6'd1, 1'b1, 1'b0);
    send_item(6'd0, 6'd1, 1'b1, 1'b0);
    send_item(6'd1, 6'd3, 1'b1, 1'b0);
    send_item(6'd2, 6'd2, 1'b1, 1'b0);
    send_item(6'd9, 6'd5, 1'b0, 1'b0);
    send_item(6'd5, 6'd0, 1'b1, 1'b0);
    send_item(6'd0, 6'd2, 1'b1, 1'b1);
    // Every vertex sits on a cycle, so nothing is safe.
    send_item(6'd0, 6'd1, 1'b1, 1'b0);
    send_item(6'd1, 6'd0, 1'b1, 1'b0);
    send_item(6'd2, 6'd3, 1'b1, 1'b0);
    send_item(6'd3, 6'd2, 1'b1, 1'b0);
    send_item(6'd0, 6'd0, 1'b0, 1'b1);
    // Count above the maximum, then lowered while the graph is still loading.
    write_vcount(7'd127);
    send_item(6'd63, 6'd0, 1'b1, 1'b0);
    send_item(6'd10, 6'd20, 1'b1, 1'b0);
    write_vcount(7'd16);
    send_item(6'd63, 6'd1, 1'b1, 1'b0);
    send_item(6'd63, 6'd63, 1'b0, 1'b1);
    // A count of zero acts as a single vertex.
    write_vcount(7'd0);
    send_item(6'd0, 6'd0, 1'b1, 1'b1);
    send_item(6'd0, 6'd0, 1'b0, 1'b1);
    write_vcount(7'd64);
    send_item(6'd63, 6'd62, 1'b1, 1'b0);
    send_item(6'd0, 6'd63, 1'b1, 1'b0);
    send_item(6'd62, 6'd0, 1'b1, 1'b0);
    send_item(6'h2A, 6'h15, 1'b1, 1'b1);

    // The first random graph overfills the edge store.
    random_graph(1'b1);
    while (sent_items < TOTAL_ITEMS) random_graph(1'b0);

    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("eventual_safe_nodes_top: match");
    end else begin
      $display("eventual_safe_nodes_top: mismatch");
    end
    $finish;
  end

endmodule
